FILE: rtl/pmq_pkg.sv
// shared types, constants and register indexes of the point morton quantizer
package pmq_pkg;

    localparam int POS_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int LEVELS_W       = 4;
    localparam int DEF_MAX_LEVELS = 10;
    localparam int IN_TDATA_W     = 3 * POS_W;

    localparam logic [POS_W-1:0]    RST_MIN    = 32'sd0;
    localparam logic [POS_W-1:0]    RST_MAX    = 32'sd65536;
    localparam logic [LEVELS_W-1:0] RST_LEVELS = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X  = 3'd0,
        CFG_MIN_Y  = 3'd1,
        CFG_MIN_Z  = 3'd2,
        CFG_MAX_X  = 3'd3,
        CFG_MAX_Y  = 3'd4,
        CFG_MAX_Z  = 3'd5,
        CFG_LEVELS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic zero;
        logic sat;
    } t_lane_flags;

endpackage

FILE: rtl/point_morton_quantizer_core.sv
// top level of the point morton quantizer: config registers, lanes, interleave
//
//  channel   | dir | fields
//  s_axis    | in  | tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
//  m_axis    | out | tdata: code[3*MAX_LEVELS-1:0], zero padded to bytes
//  cfg write | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// one point per cycle unless the output stalls; pipeline stages: offset, multiply,
// one restoring division stage per quotient bit, output register
// the whole pipeline halts while the output request waits, nothing is dropped
// synchronous active-low reset clears valid bits and loads default registers
module point_morton_quantizer_core #(
    parameter int MAX_LEVELS = pmq_pkg::DEF_MAX_LEVELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pmq_pkg::IN_TDATA_W-1:0] i_s_tdata,   // pos_x, pos_y, pos_z
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [((3*MAX_LEVELS+7)/8)*8-1:0] o_m_tdata, // code, zero padding
    input  logic                           i_cfg_we,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pmq_pkg::*;

    localparam int NS     = MAX_LEVELS + 2;
    localparam int CODE_W = 3 * MAX_LEVELS;
    localparam int OUT_W  = ((CODE_W + 7) / 8) * 8;

    logic [POS_W-1:0]    r_min [0:2];
    logic [POS_W-1:0]    r_max [0:2];
    logic [LEVELS_W-1:0] r_levels;

    logic                  en;
    logic [LEVELS_W-1:0]   lv_sat;
    logic [MAX_LEVELS-1:0] n_scale;

    logic [NS-1:0]         r_vld;
    logic [MAX_LEVELS-1:0] r_scale [0:NS-1];
    logic                  r_out_valid;
    logic [CODE_W-1:0]     r_code;
    logic [CODE_W-1:0]     n_code;

    logic [POS_W-1:0]      off   [0:2];
    logic [POS_W-1:0]      range [0:2];
    t_lane_flags           flg1  [0:2];
    logic [MAX_LEVELS-1:0] quot  [0:2];
    t_lane_flags           flg2  [0:2];
    logic [MAX_LEVELS-1:0] idx   [0:2];

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= RST_MIN;
                r_max[a] <= RST_MAX;
            end
            r_levels <= RST_LEVELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X:  r_min[0] <= i_cfg_data;
                CFG_MIN_Y:  r_min[1] <= i_cfg_data;
                CFG_MIN_Z:  r_min[2] <= i_cfg_data;
                CFG_MAX_X:  r_max[0] <= i_cfg_data;
                CFG_MAX_Y:  r_max[1] <= i_cfg_data;
                CFG_MAX_Z:  r_max[2] <= i_cfg_data;
                CFG_LEVELS: r_levels <= i_cfg_data[LEVELS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        lv_sat = (r_levels > LEVELS_W'(MAX_LEVELS)) ? LEVELS_W'(MAX_LEVELS) : r_levels;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            n_scale[k] = (LEVELS_W'(k) < lv_sat);
        end
    end

    // axis lanes
    for (genvar a = 0; a < 3; a++) begin : g_lane
        pmq_offset u_offset (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pos   (i_s_tdata[a*POS_W +: POS_W]),
            .i_min   (r_min[a]),
            .i_max   (r_max[a]),
            .o_off   (off[a]),
            .o_range (range[a]),
            .o_flags (flg1[a])
        );

        pmq_div #(
            .MAX_LEVELS (MAX_LEVELS)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_off   (off[a]),
            .i_range (range[a]),
            .i_scale (r_scale[0]),
            .i_flags (flg1[a]),
            .o_quot  (quot[a]),
            .o_flags (flg2[a])
        );
    end

    // final index per axis and bit interleave
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (flg2[a].zero) begin
                idx[a] = '0;
            end else if (flg2[a].sat) begin
                idx[a] = r_scale[NS-1];
            end else begin
                idx[a] = quot[a];
            end
        end
        for (int i = 0; i < MAX_LEVELS; i++) begin
            for (int a = 0; a < 3; a++) begin
                n_code[3*i + a] = idx[a][i];
            end
        end
    end

    // valid bits and scale travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NS-2:0], i_s_tvalid};
            r_out_valid <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_scale[0] <= n_scale;
            for (int s = 1; s < NS; s++) begin
                r_scale[s] <= r_scale[s-1];
            end
            r_code <= n_code;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_code);

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_last_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && en) |=> o_m_tvalid)
        else $error("finished request did not reach the output register");

endmodule

FILE: rtl/pmq_offset.sv
// first stage of one axis: offset and range, with the zero and saturate cases
module pmq_offset (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [pmq_pkg::POS_W-1:0] i_pos,
    input  logic [pmq_pkg::POS_W-1:0] i_min,
    input  logic [pmq_pkg::POS_W-1:0] i_max,
    output logic [pmq_pkg::POS_W-1:0] o_off,
    output logic [pmq_pkg::POS_W-1:0] o_range,
    output pmq_pkg::t_lane_flags      o_flags
);
    import pmq_pkg::*;

    logic signed [POS_W:0] off_w;
    logic signed [POS_W:0] range_w;
    t_lane_flags           n_flags;

    logic [POS_W-1:0] r_off;
    logic [POS_W-1:0] r_range;
    t_lane_flags      r_flags;

    always_comb begin
        off_w         = $signed({i_pos[POS_W-1], i_pos}) - $signed({i_min[POS_W-1], i_min});
        range_w       = $signed({i_max[POS_W-1], i_max}) - $signed({i_min[POS_W-1], i_min});
        n_flags.zero  = (range_w <= 0) || (off_w <= 0);
        n_flags.sat   = (off_w >= range_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off   <= off_w[POS_W-1:0];
            r_range <= range_w[POS_W-1:0];
            r_flags <= n_flags;
        end
    end

    assign o_off   = r_off;
    assign o_range = r_range;
    assign o_flags = r_flags;

endmodule

FILE: rtl/pmq_div.sv
// scale multiply and pipelined restoring division, one quotient bit per stage
module pmq_div #(
    parameter int MAX_LEVELS = pmq_pkg::DEF_MAX_LEVELS
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [pmq_pkg::POS_W-1:0] i_off,
    input  logic [pmq_pkg::POS_W-1:0] i_range,
    input  logic [MAX_LEVELS-1:0]     i_scale,
    input  pmq_pkg::t_lane_flags      i_flags,
    output logic [MAX_LEVELS-1:0]     o_quot,
    output pmq_pkg::t_lane_flags      o_flags
);
    import pmq_pkg::*;

    localparam int NW = POS_W + MAX_LEVELS;

    logic [NW-1:0] prod;

    logic [POS_W-1:0]      r_rem  [0:MAX_LEVELS-1];
    logic [MAX_LEVELS-1:0] r_lo   [0:MAX_LEVELS-1];
    logic [MAX_LEVELS-1:0] r_quot [0:MAX_LEVELS];
    logic [POS_W-1:0]      r_den  [0:MAX_LEVELS-1];
    t_lane_flags           r_flg  [0:MAX_LEVELS];

    logic [POS_W:0]        trial  [1:MAX_LEVELS];
    logic                  ge     [1:MAX_LEVELS];
    logic [POS_W-1:0]      diff   [1:MAX_LEVELS];
    logic [MAX_LEVELS-1:0] tq     [1:MAX_LEVELS];

    assign prod = NW'(i_off) * NW'(i_scale);

    always_comb begin
        for (int s = 1; s <= MAX_LEVELS; s++) begin
            trial[s] = {r_rem[s-1], r_lo[s-1][MAX_LEVELS-1]};
            ge[s]    = (trial[s] >= {1'b0, r_den[s-1]});
            diff[s]  = trial[s][POS_W-1:0] - r_den[s-1];
            tq[s]    = (r_quot[s-1] << 1) | MAX_LEVELS'(ge[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= prod[NW-1:MAX_LEVELS];
            r_lo[0]   <= prod[MAX_LEVELS-1:0];
            r_quot[0] <= '0;
            r_den[0]  <= i_range;
            r_flg[0]  <= i_flags;
            for (int s = 1; s < MAX_LEVELS; s++) begin
                r_rem[s] <= ge[s] ? diff[s] : trial[s][POS_W-1:0];
                r_lo[s]  <= r_lo[s-1] << 1;
                r_den[s] <= r_den[s-1];
            end
            for (int s = 1; s <= MAX_LEVELS; s++) begin
                r_quot[s] <= tq[s];
                r_flg[s]  <= r_flg[s-1];
            end
        end
    end

    assign o_quot  = r_quot[MAX_LEVELS];
    assign o_flags = r_flg[MAX_LEVELS];

endmodule

FILE: test/tb_point_morton_quantizer_core.sv
// testbench of the point morton quantizer core: directed and random points checked against a model
module tb_point_morton_quantizer_core;
    import pmq_pkg::*;

    localparam int MAX_LEVELS   = DEF_MAX_LEVELS;
    localparam int CODE_W       = 3 * MAX_LEVELS;
    localparam int OUT_W        = ((CODE_W + 7) / 8) * 8;
    localparam int LATENCY      = MAX_LEVELS + 3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 75;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [POS_W-1:0]     POS_LOW   = 32'h8000_0000;
    localparam logic [POS_W-1:0]     POS_HIGH  = 32'h7FFF_FFFF;

    class morton_checker;
        logic signed [POS_W-1:0] lo [3];
        logic signed [POS_W-1:0] hi [3];
        logic [LEVELS_W-1:0]     lvl;
        logic [CODE_W-1:0]       pending_codes [$];
        int                      fails;

        function new();
            for (int a = 0; a < 3; a++) begin
                lo[a] = RST_MIN;
                hi[a] = RST_MAX;
            end
            lvl   = RST_LEVELS;
            fails = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MIN_X:  lo[0] = val;
                CFG_MIN_Y:  lo[1] = val;
                CFG_MIN_Z:  lo[2] = val;
                CFG_MAX_X:  hi[0] = val;
                CFG_MAX_Y:  hi[1] = val;
                CFG_MAX_Z:  hi[2] = val;
                CFG_LEVELS: lvl   = val[LEVELS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [MAX_LEVELS-1:0] cell_of(logic signed [POS_W-1:0] p, int axis);
            longint off;
            longint span;
            longint scale;
            int     lv;
            lv    = (lvl > MAX_LEVELS) ? MAX_LEVELS : int'(lvl);
            off   = longint'(p) - longint'(lo[axis]);
            span  = longint'(hi[axis]) - longint'(lo[axis]);
            scale = (longint'(1) << lv) - 1;
            if (span <= 0 || off <= 0)
                return '0;
            if (off >= span)
                return scale[MAX_LEVELS-1:0];
            return MAX_LEVELS'((off * scale) / span);
        endfunction

        function void note_point(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                 logic [POS_W-1:0] z);
            logic [MAX_LEVELS-1:0] cx;
            logic [MAX_LEVELS-1:0] cy;
            logic [MAX_LEVELS-1:0] cz;
            logic [CODE_W-1:0]     c;
            cx = cell_of(x, 0);
            cy = cell_of(y, 1);
            cz = cell_of(z, 2);
            for (int i = 0; i < MAX_LEVELS; i++) begin
                c[3*i]   = cx[i];
                c[3*i+1] = cy[i];
                c[3*i+2] = cz[i];
            end
            pending_codes.push_back(c);
        endfunction

        function void check_code(logic [OUT_W-1:0] tdata);
            logic [CODE_W-1:0] want;
            if (pending_codes.size() == 0) begin
                $error("code: expected none, actual %h", tdata[CODE_W-1:0]);
                fails++;
                return;
            end
            want = pending_codes.pop_front();
            if (tdata[CODE_W-1:0] !== want) begin
                $error("code: expected %h, actual %h", want, tdata[CODE_W-1:0]);
                fails++;
            end
            if ((tdata >> CODE_W) !== '0) begin
                $error("padding: expected 0, actual %h", tdata >> CODE_W);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata  = '0;   // pos_x, pos_y, pos_z
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;         // code, zero padding
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    morton_checker sb;
    int            gap_pct   = 20;
    int            stall_pct = 20;
    int            stall_cnt = 0;

    point_morton_quantizer_core #(
        .MAX_LEVELS(MAX_LEVELS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: check accepted results, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            sb.check_code(o_m_tdata);
        if (stall_cnt > 0)
            stall_cnt = stall_cnt - 1;
        else if ($urandom_range(0, 99) < stall_pct)
            stall_cnt = $urandom_range(1, 6);
        i_m_tready <= (stall_cnt == 0);
    end

    task automatic send_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_point(x, y, z);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending_codes.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_setup(input logic [POS_W-1:0] lx, input logic [POS_W-1:0] ly,
                              input logic [POS_W-1:0] lz, input logic [POS_W-1:0] hx,
                              input logic [POS_W-1:0] hy, input logic [POS_W-1:0] hz,
                              input logic [CFG_DATA_W-1:0] lv);
        wait_drained();
        cfg_write(CFG_MIN_X, lx);
        cfg_write(CFG_MIN_Y, ly);
        cfg_write(CFG_MIN_Z, lz);
        cfg_write(CFG_MAX_X, hx);
        cfg_write(CFG_MAX_Y, hy);
        cfg_write(CFG_MAX_Z, hz);
        cfg_write(CFG_LEVELS, lv);
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_SPARE, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    task automatic roll_axis(output logic [POS_W-1:0] a, output logic [POS_W-1:0] b);
        case ($urandom_range(0, 5))
            0: begin
                a = $urandom();
                b = $urandom();
            end
            1: begin
                a = POS_LOW;
                b = POS_HIGH;
            end
            2: begin
                a = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
                b = a + $urandom_range(1, 4096);
            end
            3: begin
                a = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
                b = a - $urandom_range(0, 100);
            end
            default: begin
                a = -$urandom_range(0, 32'h1000_0000);
                b = $urandom_range(1, 32'h1000_0000);
            end
        endcase
    endtask

    function automatic logic [POS_W-1:0] roll_coord(int axis);
        longint          a;
        longint          b;
        longint          span;
        longint unsigned r;
        int              kind;
        a    = longint'(sb.lo[axis]);
        b    = longint'(sb.hi[axis]);
        span = b - a;
        r    = {$urandom(), $urandom()};
        kind = $urandom_range(0, 9);
        if (kind < 7 && span > 0)
            return POS_W'(a + longint'(r % longint'(span + 1)));
        if (kind == 8)
            return POS_W'(r[0] ? a : b);
        if (kind == 9)
            return POS_W'((r[0] ? a : b) + (r[1] ? 1 : -1));
        return r[POS_W-1:0];
    endfunction

    initial begin
        logic [POS_W-1:0] bl [3];
        logic [POS_W-1:0] bh [3];
        logic [CFG_DATA_W-1:0] lv;

        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bounds and levels
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'd65536, 32'd65536, 32'd65536);
        send_point(32'd32768, 32'd16384, 32'd49152);
        send_point(POS_LOW, POS_HIGH, 32'hFFFF_FFFF);
        send_point(32'd1, 32'd65535, 32'd65537);
        send_point(32'h0000_5555, 32'h0000_AAAA, 32'h0000_FFC0);

        // reversed, empty and normal range on one level
        load_setup(32'd1000, 32'd500, 32'd0, 32'd999, 32'd500, 32'd65536, 32'd1);
        send_point(32'd1000, 32'd500, 32'd32767);
        send_point(32'd998, 32'd501, 32'd32768);
        send_point(POS_HIGH, POS_LOW, 32'd65536);
        send_point(POS_LOW, POS_HIGH, 32'hFFFF_0000);

        // zero levels
        load_setup(POS_LOW, POS_LOW, POS_LOW, POS_HIGH, POS_HIGH, POS_HIGH, 32'd0);
        send_point(32'd0, POS_HIGH, 32'h1234_5678);
        send_point(POS_HIGH, 32'h4000_0000, POS_LOW);

        // levels above the maximum saturate, widest range
        load_setup(POS_LOW, POS_LOW, POS_LOW, POS_HIGH, POS_HIGH, POS_HIGH, 32'hFFFF_FFFF);
        send_point(POS_LOW, POS_HIGH, 32'd0);
        send_point(POS_HIGH - 32'd1, POS_LOW + 32'd1, 32'hFFFF_FFFF);
        send_point(32'h4000_0000, 32'hC000_0000, 32'h7FC0_0000);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int a = 0; a < 3; a++)
                roll_axis(bl[a], bh[a]);
            lv = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(1, MAX_LEVELS));
            load_setup(bl[0], bl[1], bl[2], bh[0], bh[1], bh[2], lv);
            if (ph == RAND_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_point(roll_coord(0), roll_coord(1), roll_coord(2));
            end
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pmq_pkg.sv
rtl/pmq_offset.sv
rtl/pmq_div.sv
rtl/point_morton_quantizer_core.sv
test/tb_point_morton_quantizer_core.sv
